// ===== design/terminal_line_editor_defines.svh =====
// Assertion macros used by the checker file.
`ifndef TERMINAL_LINE_EDITOR_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tle_pkg.sv =====
package tle_pkg;

   localparam int LINE_MAX_DEF = 32;
   localparam int MAX_RUN      = 48;
   localparam int RUN_AW       = 6;
   localparam int CALC_W       = 8;
   localparam int CSR_AW       = 3;

   // result kinds
   localparam logic [1:0] KIND_TERM = 2'd0;
   localparam logic [1:0] KIND_LINE = 2'd1;
   localparam logic [1:0] KIND_READ = 2'd2;

   // input actions
   localparam logic ACT_CHAR = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // echo modes
   localparam logic [1:0] ECHO_MUTE = 2'd0;
   localparam logic [1:0] ECHO_ON   = 2'd1;
   localparam logic [1:0] ECHO_STAR = 2'd2;

   // register indexes
   localparam logic CSR_ECHO_MODE  = 1'b0;
   localparam logic CSR_LINE_LIMIT = 1'b1;

   // escape parser states
   localparam logic [1:0] PS_PLAIN   = 2'd0;
   localparam logic [1:0] PS_ESC     = 2'd1;
   localparam logic [1:0] PS_BRACKET = 2'd2;
   localparam logic [1:0] PS_BIGO    = 2'd3;

   // character codes
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_SEMI  = 8'd59;
   localparam logic [7:0] CH_UC_C  = 8'd67;
   localparam logic [7:0] CH_UC_D  = 8'd68;
   localparam logic [7:0] CH_UC_K  = 8'd75;
   localparam logic [7:0] CH_UC_O  = 8'd79;
   localparam logic [7:0] CH_LBRK  = 8'd91;
   localparam logic [7:0] CH_TILDE = 8'd126;
   localparam logic [7:0] CH_DEL   = 8'd127;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [4:0] len;
   } tle_word_type;

   // sequencer to result buffer
   typedef struct packed {
      logic         push;
      logic         seal;
      tle_word_type word;
   } tle_push_type;

endpackage

// ===== design/tle_if.sv =====
interface tle_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] char_in;
   logic [4:0] read_index;

   modport source (output valid, action, char_in, read_index, input ready);
   modport sink   (input valid, action, char_in, read_index, output ready);
endinterface

interface tle_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic [4:0] line_length;
   logic       last;

   modport source (output valid, kind, out_byte, line_length, last, input ready);
   modport sink   (input valid, kind, out_byte, line_length, last, output ready);
endinterface

// ===== design/tle_core.sv =====
module tle_core #(
   parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           echo_mode,
   input  logic [5:0]           line_limit,
   tle_req_if.sink              req,
   input  logic                 buf_busy,
   output tle_pkg::tle_push_type push
);
   import tle_pkg::*;

   localparam int AW = $clog2(LINE_MAX);

   localparam logic [5:0] S_IDLE     = 6'd0;
   localparam logic [5:0] S_SEAL     = 6'd1;
   localparam logic [5:0] S_RD_OUT   = 6'd2;
   localparam logic [5:0] S_CR1      = 6'd3;
   localparam logic [5:0] S_CR2      = 6'd4;
   localparam logic [5:0] S_CR3      = 6'd5;
   localparam logic [5:0] S_MV_ESC   = 6'd6;
   localparam logic [5:0] S_MV_BR    = 6'd7;
   localparam logic [5:0] S_MV_TENS  = 6'd8;
   localparam logic [5:0] S_MV_ONES  = 6'd9;
   localparam logic [5:0] S_MV_FIN   = 6'd10;
   localparam logic [5:0] S_EK_ESC   = 6'd11;
   localparam logic [5:0] S_EK_BR    = 6'd12;
   localparam logic [5:0] S_EK_K     = 6'd13;
   localparam logic [5:0] S_BS       = 6'd14;
   localparam logic [5:0] S_RMV_RD   = 6'd15;
   localparam logic [5:0] S_RMV_WR   = 6'd16;
   localparam logic [5:0] S_RMV_END  = 6'd17;
   localparam logic [5:0] S_INS_RD   = 6'd18;
   localparam logic [5:0] S_INS_WR   = 6'd19;
   localparam logic [5:0] S_INS_END  = 6'd20;
   localparam logic [5:0] S_DEL_RD   = 6'd21;
   localparam logic [5:0] S_DEL_WR   = 6'd22;
   localparam logic [5:0] S_DEL_END  = 6'd23;
   localparam logic [5:0] S_NW_RD    = 6'd24;
   localparam logic [5:0] S_NW_CHK   = 6'd25;
   localparam logic [5:0] S_PW_RD    = 6'd26;
   localparam logic [5:0] S_PW_CHK   = 6'd27;
   localparam logic [5:0] S_BO_END   = 6'd28;
   localparam logic [5:0] S_EW_FIRST = 6'd29;
   localparam logic [5:0] S_EW_END   = 6'd30;
   localparam logic [5:0] S_EW_CP_RD = 6'd31;
   localparam logic [5:0] S_EW_CP_WR = 6'd32;
   localparam logic [5:0] S_EW_FIN   = 6'd33;

   function automatic logic [5:0] mv_next(input logic [AW-1:0] m, input logic [5:0] back);
      return (m == '0) ? back : S_MV_ESC;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
   endfunction

   logic [5:0]    state_ff, state_in;
   logic [AW-1:0] len_ff, len_in;
   logic [AW-1:0] cur_ff, cur_in;
   logic [1:0]    pstate_ff, pstate_in;
   logic [15:0]   param_ff, param_in;
   logic [5:0]    ret_ff, ret_in;
   logic [5:0]    ek_ret_ff, ek_ret_in;
   logic [5:0]    scan_ret_ff, scan_ret_in;
   logic [AW-1:0] mag_ff, mag_in;
   logic          dir_ff, dir_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]    carry_ff, carry_in;
   logic [AW-1:0] scan_ff, scan_in;
   logic          phase_ff, phase_in;
   logic [AW-1:0] first_ff, first_in;
   logic [AW-1:0] gap_ff, gap_in;
   logic [AW-1:0] newlen_ff, newlen_in;
   logic [AW-1:0] final_ff, final_in;
   logic          rd_ok_ff, rd_ok_in;

   logic [7:0]    line_mem [LINE_MAX];
   logic [7:0]    mem_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [7:0]    mem_wdata;

   logic              accept;
   logic              echo_on, star, word_mode;
   logic [7:0]        c;
   logic [CALC_W-1:0] lim_w, cap_w, rd_index_w;
   logic              ins_ok;
   logic [19:0]       p_mul;
   logic [15:0]       param_next, p_eff;
   logic [AW-1:0]     room_r, n_r, n_l, bo_mag, ew_newlen, ew_final, ew_dst;
   logic [CALC_W-1:0] ew_min;
   logic              rd_sp;
   logic [7:0]        shown_rd, shown_carry;
   logic [13:0]       tens_prod;
   logic [2:0]        tens;
   logic [3:0]        ones;

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == S_IDLE) && !buf_busy;
   assign c         = req.char_in;

   assign echo_on   = (echo_mode == ECHO_ON) || (echo_mode == ECHO_STAR);
   assign star      = (echo_mode == ECHO_STAR);
   assign word_mode = (echo_mode == ECHO_ON);

   assign lim_w  = (CALC_W'(line_limit) < CALC_W'(LINE_MAX)) ? CALC_W'(line_limit)
                                                              : CALC_W'(LINE_MAX);
   assign cap_w  = (lim_w >= CALC_W'(2)) ? lim_w - CALC_W'(2) : '0;
   assign ins_ok = (CALC_W'(len_ff) + CALC_W'(2)) < lim_w;
   assign rd_index_w = CALC_W'(req.read_index);

   // decimal accumulate, saturating at 16 bits
   assign p_mul = ({4'b0, param_ff} << 3) + ({4'b0, param_ff} << 1) + 20'(c - CH_ZERO);
   assign param_next = (p_mul > 20'd65535) ? 16'hFFFF : p_mul[15:0];
   assign p_eff  = (param_ff == '0) ? 16'd1 : param_ff;
   assign room_r = len_ff - cur_ff;
   assign n_r    = (16'(room_r) < p_eff) ? room_r : p_eff[AW-1:0];
   assign n_l    = (16'(cur_ff) < p_eff) ? cur_ff : p_eff[AW-1:0];
   assign bo_mag = (scan_ff >= cur_ff) ? scan_ff - cur_ff : cur_ff - scan_ff;

   // erase-word refill stops once the line reaches the insert limit
   assign ew_newlen = len_ff - (scan_ff - first_ff);
   assign ew_min    = (CALC_W'(ew_newlen) < cap_w) ? CALC_W'(ew_newlen) : cap_w;
   assign ew_final  = (ew_min > CALC_W'(first_ff)) ? ew_min[AW-1:0] : first_ff;
   assign ew_dst    = idx_ff - gap_ff;

   assign rd_sp       = is_space(mem_rdata_ff);
   assign shown_rd    = star ? CH_STAR : mem_rdata_ff;
   assign shown_carry = star ? CH_STAR : carry_ff;

   // magnitude stays below 100: divide by ten through a reciprocal
   assign tens_prod = 14'(mag_ff) * 14'd205;
   assign tens      = tens_prod[13:11];
   assign ones      = 4'(CALC_W'(mag_ff) - CALC_W'(tens) * CALC_W'(10));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= line_mem[mem_raddr];
   end

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      cur_in      = cur_ff;
      pstate_in   = pstate_ff;
      param_in    = param_ff;
      ret_in      = ret_ff;
      ek_ret_in   = ek_ret_ff;
      scan_ret_in = scan_ret_ff;
      mag_in      = mag_ff;
      dir_in      = dir_ff;
      idx_in      = idx_ff;
      carry_in    = carry_ff;
      scan_in     = scan_ff;
      phase_in    = phase_ff;
      first_in    = first_ff;
      gap_in      = gap_ff;
      newlen_in   = newlen_ff;
      final_in    = final_ff;
      rd_ok_in    = rd_ok_ff;
      mem_we      = 1'b0;
      mem_waddr   = idx_ff;
      mem_wdata   = carry_ff;
      mem_raddr   = idx_ff;
      push        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               ret_in = S_SEAL;
               if (req.action == ACT_READ) begin
                  mem_raddr = rd_index_w[AW-1:0];
                  rd_ok_in  = rd_index_w < CALC_W'(len_ff);
                  state_in  = S_RD_OUT;
               end else if (c == CH_LF || c == CH_CR) begin
                  state_in = S_CR1;
               end else begin
                  state_in = S_SEAL;
                  case (pstate_ff)
                     PS_PLAIN: begin
                        if (c == CH_ESC) begin
                           pstate_in = PS_ESC;
                        end else if (c == CH_DEL) begin
                           if (cur_ff != '0) begin
                              idx_in    = cur_ff;
                              ek_ret_in = S_RMV_RD;
                              state_in  = echo_on ? S_BS : S_RMV_RD;
                           end
                        end else if (c == CH_BS) begin
                           if (word_mode) begin
                              scan_in     = cur_ff;
                              phase_in    = 1'b0;
                              scan_ret_in = S_EW_FIRST;
                              state_in    = S_PW_RD;
                           end
                        end else if (c >= CH_SPACE && c < CH_DEL) begin
                           if (ins_ok) begin
                              carry_in  = c;
                              idx_in    = cur_ff;
                              ek_ret_in = S_INS_RD;
                              state_in  = (cur_ff < len_ff && echo_on) ? S_EK_ESC : S_INS_RD;
                           end
                        end
                     end
                     PS_ESC: begin
                        if (c == CH_LBRK) begin
                           pstate_in = PS_BRACKET;
                           param_in  = '0;
                        end else if (c == CH_UC_O) begin
                           pstate_in = PS_BIGO;
                        end else begin
                           pstate_in = PS_PLAIN;
                        end
                     end
                     PS_BRACKET: begin
                        if (c == CH_SEMI) begin
                           param_in = '0;
                        end else if (c >= CH_ZERO && c <= CH_NINE) begin
                           param_in = param_next;
                        end else begin
                           pstate_in = PS_PLAIN;
                           if (c == CH_UC_C) begin
                              cur_in = cur_ff + n_r;
                              mag_in = n_r;
                              dir_in = 1'b1;
                              if (echo_on) state_in = mv_next(n_r, S_SEAL);
                           end else if (c == CH_UC_D) begin
                              cur_in = cur_ff - n_l;
                              mag_in = n_l;
                              dir_in = 1'b0;
                              if (echo_on) state_in = mv_next(n_l, S_SEAL);
                           end else if (c == CH_TILDE) begin
                              if (param_ff == 16'd1) begin
                                 cur_in = '0;
                                 mag_in = cur_ff;
                                 dir_in = 1'b0;
                                 if (echo_on) state_in = mv_next(cur_ff, S_SEAL);
                              end else if (param_ff == 16'd3) begin
                                 if (cur_ff < len_ff) begin
                                    len_in    = len_ff - 1'b1;
                                    idx_in    = cur_ff;
                                    ek_ret_in = S_DEL_RD;
                                    state_in  = echo_on ? S_EK_ESC : S_DEL_RD;
                                 end
                              end else if (param_ff == 16'd4) begin
                                 cur_in = len_ff;
                                 mag_in = room_r;
                                 dir_in = 1'b1;
                                 if (echo_on) state_in = mv_next(room_r, S_SEAL);
                              end
                           end
                        end
                     end
                     default: begin
                        pstate_in = PS_PLAIN;
                        if (word_mode && (c == CH_UC_C || c == CH_UC_D)) begin
                           scan_in     = cur_ff;
                           phase_in    = 1'b0;
                           scan_ret_in = S_BO_END;
                           state_in    = (c == CH_UC_C) ? S_NW_RD : S_PW_RD;
                        end
                     end
                  endcase
               end
            end
         end
         S_RD_OUT: begin
            push.push      = 1'b1;
            push.word.kind = KIND_READ;
            push.word.data = rd_ok_ff ? mem_rdata_ff : 8'd0;
            state_in       = S_SEAL;
         end
         S_CR1: begin
            push.push      = 1'b1;
            push.word.data = CH_CR;
            state_in       = S_CR2;
         end
         S_CR2: begin
            push.push      = 1'b1;
            push.word.data = CH_LF;
            state_in       = S_CR3;
         end
         S_CR3: begin
            push.push      = 1'b1;
            push.word.kind = KIND_LINE;
            push.word.len  = 5'(CALC_W'(len_ff));
            len_in         = '0;
            cur_in         = '0;
            state_in       = S_SEAL;
         end
         S_MV_ESC: begin
            push.push      = 1'b1;
            push.word.data = CH_ESC;
            state_in       = S_MV_BR;
         end
         S_MV_BR: begin
            push.push      = 1'b1;
            push.word.data = CH_LBRK;
            if (mag_ff == AW'(1))  state_in = S_MV_FIN;
            else if (tens == '0)   state_in = S_MV_ONES;
            else                   state_in = S_MV_TENS;
         end
         S_MV_TENS: begin
            push.push      = 1'b1;
            push.word.data = CH_ZERO + 8'(tens);
            state_in       = S_MV_ONES;
         end
         S_MV_ONES: begin
            push.push      = 1'b1;
            push.word.data = CH_ZERO + 8'(ones);
            state_in       = S_MV_FIN;
         end
         S_MV_FIN: begin
            push.push      = 1'b1;
            push.word.data = dir_ff ? CH_UC_C : CH_UC_D;
            state_in       = ret_ff;
         end
         S_EK_ESC: begin
            push.push      = 1'b1;
            push.word.data = CH_ESC;
            state_in       = S_EK_BR;
         end
         S_EK_BR: begin
            push.push      = 1'b1;
            push.word.data = CH_LBRK;
            state_in       = S_EK_K;
         end
         S_EK_K: begin
            push.push      = 1'b1;
            push.word.data = CH_UC_K;
            state_in       = ek_ret_ff;
         end
         S_BS: begin
            push.push      = 1'b1;
            push.word.data = CH_BS;
            state_in       = S_EK_ESC;
         end
         S_RMV_RD: begin
            if (idx_ff < len_ff) state_in = S_RMV_WR;
            else                 state_in = S_RMV_END;
         end
         S_RMV_WR: begin
            mem_we         = 1'b1;
            mem_waddr      = idx_ff - 1'b1;
            mem_wdata      = mem_rdata_ff;
            push.push      = echo_on;
            push.word.data = shown_rd;
            idx_in         = idx_ff + 1'b1;
            state_in       = S_RMV_RD;
         end
         S_RMV_END: begin
            cur_in   = cur_ff - 1'b1;
            len_in   = len_ff - 1'b1;
            mag_in   = room_r;
            dir_in   = 1'b0;
            ret_in   = S_SEAL;
            state_in = echo_on ? mv_next(room_r, S_SEAL) : S_SEAL;
         end
         S_INS_RD: begin
            if (idx_ff <= len_ff) state_in = S_INS_WR;
            else                  state_in = S_INS_END;
         end
         S_INS_WR: begin
            mem_we         = 1'b1;
            push.push      = echo_on;
            push.word.data = shown_carry;
            carry_in       = mem_rdata_ff;
            idx_in         = idx_ff + 1'b1;
            state_in       = S_INS_RD;
         end
         S_INS_END: begin
            cur_in   = cur_ff + 1'b1;
            len_in   = len_ff + 1'b1;
            mag_in   = room_r;
            dir_in   = 1'b0;
            ret_in   = S_SEAL;
            state_in = echo_on ? mv_next(room_r, S_SEAL) : S_SEAL;
         end
         S_DEL_RD: begin
            mem_raddr = idx_ff + 1'b1;
            if (idx_ff < len_ff) state_in = S_DEL_WR;
            else                 state_in = S_DEL_END;
         end
         S_DEL_WR: begin
            mem_we         = 1'b1;
            mem_wdata      = mem_rdata_ff;
            push.push      = echo_on;
            push.word.data = shown_rd;
            idx_in         = idx_ff + 1'b1;
            state_in       = S_DEL_RD;
         end
         S_DEL_END: begin
            mag_in   = room_r;
            dir_in   = 1'b0;
            ret_in   = S_SEAL;
            state_in = echo_on ? mv_next(room_r, S_SEAL) : S_SEAL;
         end
         S_NW_RD: begin
            mem_raddr = scan_ff;
            if (scan_ff < len_ff) state_in = S_NW_CHK;
            else                  state_in = scan_ret_ff;
         end
         S_NW_CHK: begin
            // skip the word, then the blanks after it
            if (!phase_ff || rd_sp) begin
               scan_in  = scan_ff + 1'b1;
               if (rd_sp) phase_in = 1'b1;
               state_in = S_NW_RD;
            end else begin
               state_in = scan_ret_ff;
            end
         end
         S_PW_RD: begin
            mem_raddr = scan_ff - 1'b1;
            if (scan_ff != '0) state_in = S_PW_CHK;
            else               state_in = scan_ret_ff;
         end
         S_PW_CHK: begin
            // skip blanks before the cursor, then the word
            if (!phase_ff || !rd_sp) begin
               scan_in  = scan_ff - 1'b1;
               if (!rd_sp) phase_in = 1'b1;
               state_in = S_PW_RD;
            end else begin
               state_in = scan_ret_ff;
            end
         end
         S_BO_END: begin
            cur_in   = scan_ff;
            mag_in   = bo_mag;
            dir_in   = scan_ff >= cur_ff;
            ret_in   = S_SEAL;
            state_in = mv_next(bo_mag, S_SEAL);
         end
         S_EW_FIRST: begin
            first_in    = scan_ff;
            phase_in    = 1'b0;
            scan_ret_in = S_EW_END;
            state_in    = S_NW_RD;
         end
         S_EW_END: begin
            gap_in    = scan_ff - first_ff;
            newlen_in = ew_newlen;
            final_in  = ew_final;
            idx_in    = scan_ff;
            mag_in    = cur_ff - first_ff;
            dir_in    = 1'b0;
            ret_in    = S_EK_ESC;
            ek_ret_in = S_EW_CP_RD;
            state_in  = mv_next(cur_ff - first_ff, S_EK_ESC);
         end
         S_EW_CP_RD: begin
            if (idx_ff < len_ff) state_in = S_EW_CP_WR;
            else                 state_in = S_EW_FIN;
         end
         S_EW_CP_WR: begin
            mem_we         = 1'b1;
            mem_waddr      = ew_dst;
            mem_wdata      = mem_rdata_ff;
            push.push      = ew_dst < final_ff;
            push.word.data = mem_rdata_ff;
            idx_in         = idx_ff + 1'b1;
            state_in       = S_EW_CP_RD;
         end
         S_EW_FIN: begin
            len_in   = final_ff;
            cur_in   = first_ff;
            mag_in   = newlen_ff - first_ff;
            dir_in   = 1'b0;
            ret_in   = S_SEAL;
            state_in = mv_next(newlen_ff - first_ff, S_SEAL);
         end
         S_SEAL: begin
            push.seal = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= '0;
         cur_ff    <= '0;
         pstate_ff <= PS_PLAIN;
         param_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         cur_ff    <= cur_in;
         pstate_ff <= pstate_in;
         param_ff  <= param_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      ek_ret_ff   <= ek_ret_in;
      scan_ret_ff <= scan_ret_in;
      mag_ff      <= mag_in;
      dir_ff      <= dir_in;
      idx_ff      <= idx_in;
      carry_ff    <= carry_in;
      scan_ff     <= scan_in;
      phase_ff    <= phase_in;
      first_ff    <= first_in;
      gap_ff      <= gap_in;
      newlen_ff   <= newlen_in;
      final_ff    <= final_in;
      rd_ok_ff    <= rd_ok_in;
   end

endmodule

// ===== design/tle_run_buf.sv =====
module tle_run_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  tle_pkg::tle_push_type push,
   output logic                  busy,
   tle_rsp_if.source             rsp
);
   import tle_pkg::*;

   tle_word_type        run_mem [MAX_RUN];
   tle_word_type        rdata_ff;
   logic [RUN_AW-1:0]   count_ff, count_in;
   logic [RUN_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic                drain_ff, drain_in;
   logic                show_ff, show_in;
   logic                wr_en;
   logic                at_last;

   // words past the run limit are dropped
   assign wr_en   = push.push && (count_ff < RUN_AW'(MAX_RUN));
   assign at_last = rd_ptr_ff == (count_ff - 1'b1);
   assign busy    = drain_ff;

   assign rsp.valid       = show_ff;
   assign rsp.kind        = rdata_ff.kind;
   assign rsp.out_byte    = rdata_ff.data;
   assign rsp.line_length = rdata_ff.len;
   assign rsp.last        = at_last;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         run_mem[count_ff] <= push.word;
      end
      rdata_ff <= run_mem[rd_ptr_ff];
   end

   always_comb begin
      count_in  = count_ff;
      rd_ptr_in = rd_ptr_ff;
      drain_in  = drain_ff;
      show_in   = show_ff;
      if (wr_en) begin
         count_in = count_ff + 1'b1;
      end
      if (push.seal && count_ff != '0) begin
         drain_in  = 1'b1;
         show_in   = 1'b0;
         rd_ptr_in = '0;
      end
      if (drain_ff) begin
         if (!show_ff) begin
            show_in = 1'b1;
         end else if (rsp.ready) begin
            show_in = 1'b0;
            if (at_last) begin
               drain_in = 1'b0;
               count_in = '0;
            end else begin
               rd_ptr_in = rd_ptr_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         drain_ff  <= 1'b0;
         show_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         drain_ff  <= drain_in;
         show_ff   <= show_in;
      end
   end

endmodule

// ===== design/terminal_line_editor.sv =====
// Terminal line editor: takes received characters one word at a time, parses
// ESC, ESC[ (decimal parameter, ';' clears it) and ESC O sequences, edits a line
// held in a line memory, and returns a run of result words (echo
// bytes, cursor-move escapes, line-complete length, or a read-back byte) with
// last set on the final word of the run. Runs longer than 48 words are cut.
// Work is one item at a time: req.ready stays low until the whole run has been
// taken. An item that gives no result words is accepted, then closed. Beyond
// that the sequencer emits each byte that is not a shifted character, shifts or
// scans each line character with a registered memory read followed by a write
// or compare, and leaves each loop through its own state; the run buffer then
// hands out each result word, holding it while the receiver stalls.
// Configuration: echo_mode at byte 0, line_limit at byte 4.
module terminal_line_editor #(
   parameter int LINE_MAX = tle_pkg::LINE_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   tle_req_if.sink                    req,
   tle_rsp_if.source                  rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [tle_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import tle_pkg::*;

   logic [1:0]   echo_mode_ff, echo_mode_in;
   logic [5:0]   line_limit_ff, line_limit_in;
   logic         csr_wr;
   logic         csr_index;
   logic         buf_busy;
   tle_push_type push;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      echo_mode_in  = echo_mode_ff;
      line_limit_in = line_limit_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_ECHO_MODE:  echo_mode_in  = csr_pwdata[1:0];
            CSR_LINE_LIMIT: line_limit_in = csr_pwdata[5:0];
            default: ;
         endcase
      end
      unique case (csr_index)
         CSR_ECHO_MODE:  csr_prdata = {30'b0, echo_mode_ff};
         CSR_LINE_LIMIT: csr_prdata = {26'b0, line_limit_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_mode_ff  <= ECHO_ON;
         line_limit_ff <= 6'd32;
      end else begin
         echo_mode_ff  <= echo_mode_in;
         line_limit_ff <= line_limit_in;
      end
   end

   tle_core #(
      .LINE_MAX (LINE_MAX)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .echo_mode  (echo_mode_ff),
      .line_limit (line_limit_ff),
      .req        (req),
      .buf_busy   (buf_busy),
      .push       (push)
   );

   tle_run_buf u_run_buf (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .busy  (buf_busy),
      .rsp   (rsp)
   );

endmodule

// ===== design/tle_checker.sv =====
`include "terminal_line_editor_defines.svh"

module tle_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_out_byte,
   input logic [4:0] rsp_line_length,
   input logic       rsp_last
);
   import tle_pkg::*;

   `TLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last), "stalled result word changed")
   `TLE_ASSERT_IMPL(a_busy_while_run, clock, reset, rsp_valid, !req_ready, "input taken while a run drains")
   `TLE_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after accept")
   `TLE_ASSERT_IMPL(a_line_byte_zero, clock, reset, rsp_valid && rsp_kind == KIND_LINE, rsp_out_byte == 8'd0, "line complete word carries a byte")
   `TLE_ASSERT_IMPL(a_len_only_line, clock, reset, rsp_valid && rsp_kind != KIND_LINE, rsp_line_length == 5'd0, "length set on a non-line word")

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_kind        (rsp.kind),
   .rsp_out_byte    (rsp.out_byte),
   .rsp_line_length (rsp.line_length),
   .rsp_last        (rsp.last)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import tle_pkg::*;

   typedef struct packed {
      logic       action;
      logic [7:0] ch;
      logic [4:0] idx;
   } key_word_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [4:0] len;
      logic       last;
   } echo_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   tle_req_if req ();
   tle_rsp_if rsp ();

   terminal_line_editor u_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // editor model state
   logic [7:0] m_line [LINE_MAX_DEF];
   int unsigned m_len, m_cur, m_pstate, m_param;
   int unsigned m_echo = 1, m_limit = 32;
   echo_word_type run_q [$];
   echo_word_type expected_q [$];

   key_word_type pending_q [$];
   int errors = 0;
   int unsigned cycles = 0;
   bit feed_hold = 1'b0;

   function automatic void emit(logic [1:0] k, int unsigned b, int unsigned l);
      echo_word_type w;
      if (run_q.size() >= MAX_RUN) return;
      w.kind = k; w.data = b[7:0]; w.len = l[4:0]; w.last = 1'b0;
      run_q.push_back(w);
   endfunction

   function automatic bit echoing();
      return m_echo == ECHO_ON || m_echo == ECHO_STAR;
   endfunction

   function automatic int unsigned shown(int unsigned c);
      return m_echo == ECHO_STAR ? CH_STAR : c;
   endfunction

   function automatic bit blank(int unsigned c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic void move_cols(int n);
      int unsigned a;
      int k;
      logic [7:0] d [8];
      k = 0;
      if (n == 0) return;
      a = n < 0 ? -n : n;
      emit(KIND_TERM, CH_ESC, 0);
      emit(KIND_TERM, CH_LBRK, 0);
      if (a != 1) begin
         while (a != 0 && k < 8) begin
            d[k] = 8'(CH_ZERO + a % 10); k++; a /= 10;
         end
         while (k > 0) begin
            k--; emit(KIND_TERM, d[k], 0);
         end
      end
      emit(KIND_TERM, n < 0 ? CH_UC_D : CH_UC_C, 0);
   endfunction

   function automatic void erase_eol();
      emit(KIND_TERM, CH_ESC, 0); emit(KIND_TERM, CH_LBRK, 0); emit(KIND_TERM, CH_UC_K, 0);
   endfunction

   function automatic int unsigned word_fwd(int unsigned p, int unsigned e);
      while (p < e && p < LINE_MAX_DEF && !blank(m_line[p])) p++;
      while (p < e && p < LINE_MAX_DEF && blank(m_line[p])) p++;
      return p;
   endfunction

   function automatic int unsigned word_back(int unsigned p);
      while (p > 0 && p <= LINE_MAX_DEF && blank(m_line[p-1])) p--;
      while (p > 0 && p <= LINE_MAX_DEF && !blank(m_line[p-1])) p--;
      return p;
   endfunction

   function automatic void insert_at_cursor(int unsigned c);
      int unsigned t, lim;
      lim = m_limit < LINE_MAX_DEF ? m_limit : LINE_MAX_DEF;
      if (m_len + 2 >= lim) return;
      if (m_cur < m_len && echoing()) erase_eol();
      for (int unsigned i = m_cur; i <= m_len && i < LINE_MAX_DEF; i++) begin
         if (echoing()) emit(KIND_TERM, shown(c), 0);
         t = m_line[i]; m_line[i] = c[7:0]; c = t;
      end
      m_cur++; m_len++;
      if (echoing()) move_cols(int'(m_cur) - int'(m_len));
   endfunction

   function automatic void rubout();
      if (m_cur == 0) return;
      if (echoing()) begin
         emit(KIND_TERM, CH_BS, 0); erase_eol();
      end
      for (int unsigned i = m_cur; i < m_len && i < LINE_MAX_DEF; i++) begin
         m_line[i-1] = m_line[i];
         if (echoing()) emit(KIND_TERM, shown(m_line[i]), 0);
      end
      m_cur--; m_len--;
      if (echoing()) move_cols(int'(m_cur) - int'(m_len));
   endfunction

   function automatic void delete_under();
      if (m_cur >= m_len) return;
      m_len--;
      if (echoing()) erase_eol();
      for (int unsigned i = m_cur; i < m_len && i + 1 < LINE_MAX_DEF; i++) begin
         m_line[i] = m_line[i+1];
         if (echoing()) emit(KIND_TERM, shown(m_line[i]), 0);
      end
      if (echoing()) move_cols(int'(m_cur) - int'(m_len));
   endfunction

   function automatic void kill_word();
      int unsigned first, stop, oldlen, newlen;
      if (m_echo != ECHO_ON) return;
      first = word_back(m_cur);
      stop = word_fwd(first, m_len);
      move_cols(int'(first) - int'(m_cur));
      oldlen = m_len; m_len = first; m_cur = first;
      erase_eol();
      if (oldlen > stop && oldlen <= LINE_MAX_DEF)
         for (int unsigned i = 0; i < oldlen - stop; i++) m_line[first+i] = m_line[stop+i];
      newlen = oldlen - (stop - first);
      for (int unsigned i = first; i < newlen && i < LINE_MAX_DEF; i++)
         insert_at_cursor(m_line[i]);
      move_cols(int'(first) - int'(newlen));
      m_cur = first;
   endfunction

   function automatic void csi_final(int unsigned c);
      int unsigned p, room, n;
      if (c == CH_UC_C || c == CH_UC_D) begin
         p = m_param == 0 ? 1 : m_param;
         room = c == CH_UC_C ? m_len - m_cur : m_cur;
         n = room < p ? room : p;
         if (echoing()) move_cols(c == CH_UC_C ? int'(n) : -int'(n));
         if (c == CH_UC_C) m_cur += n; else m_cur -= n;
      end else if (c == CH_TILDE) begin
         if (m_param == 1) begin
            if (echoing()) move_cols(-int'(m_cur));
            m_cur = 0;
         end else if (m_param == 3) begin
            delete_under();
         end else if (m_param == 4) begin
            if (echoing()) move_cols(int'(m_len) - int'(m_cur));
            m_cur = m_len;
         end
      end
   endfunction

   function automatic void edit_key(int unsigned c);
      int unsigned p, v;
      if (c == CH_LF || c == CH_CR) begin
         emit(KIND_TERM, CH_CR, 0); emit(KIND_TERM, CH_LF, 0);
         emit(KIND_LINE, 0, m_len);
         m_len = 0; m_cur = 0;
         return;
      end
      case (m_pstate)
         PS_PLAIN: begin
            if (c == CH_ESC) m_pstate = PS_ESC;
            else if (c == CH_DEL) rubout();
            else if (c == CH_BS) kill_word();
            else if (c >= 32 && c <= 126) insert_at_cursor(c);
         end
         PS_ESC: begin
            if (c == CH_LBRK) begin
               m_pstate = PS_BRACKET; m_param = 0;
            end else if (c == CH_UC_O) m_pstate = PS_BIGO;
            else m_pstate = PS_PLAIN;
         end
         PS_BRACKET: begin
            if (c == CH_SEMI) m_param = 0;
            else if (c >= CH_ZERO && c <= CH_NINE) begin
               v = m_param * 10 + (c - CH_ZERO);
               m_param = v > 65535 ? 65535 : v;
            end else begin
               csi_final(c); m_pstate = PS_PLAIN;
            end
         end
         default: begin
            m_pstate = PS_PLAIN;
            if (m_echo == ECHO_ON && (c == CH_UC_C || c == CH_UC_D)) begin
               p = c == CH_UC_C ? word_fwd(m_cur, m_len) : word_back(m_cur);
               move_cols(int'(p) - int'(m_cur));
               m_cur = p;
            end
         end
      endcase
   endfunction

   function automatic void predict_key(key_word_type k);
      run_q.delete();
      if (k.action == ACT_READ)
         emit(KIND_READ, (k.idx < m_len) ? m_line[k.idx] : 0, 0);
      else
         edit_key(k.ch);
      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.action <= 1'b0; req.char_in <= '0; req.read_index <= '0;
      end else begin
         if (req.valid && req.ready) predict_key({req.action, req.char_in, req.read_index});
         if (!req.valid || req.ready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req.valid <= 1'b0;
            end else if (pending_q.size() > 0 && !feed_hold) begin
               key_word_type k;
               k = pending_q.pop_front();
               req.valid <= 1'b1;
               req.action <= k.action; req.char_in <= k.ch; req.read_index <= k.idx;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else burst_left <= burst_left - 1;
            end else req.valid <= 1'b0;
         end
      end
   end

   // monitor with receiver stall pattern
   logic [15:0] stall_pat = 16'hffff;
   int unsigned pat_ptr = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            echo_word_type got, want;
            got = {rsp.kind, rsp.out_byte, rsp.line_length, rsp.last};
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected word %h", got);
            end else begin
               want = expected_q.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp kind=%0d byte=%h len=%0d last=%b,",
                              want.kind, want.data, want.len, want.last,
                              " got kind=%0d byte=%h len=%0d last=%b",
                              got.kind, got.data, got.len, got.last);
               end
            end
         end
         pat_ptr <= pat_ptr + 1;
         if (pat_ptr % 200 == 0)
            stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
         rsp.ready <= stall_pat[pat_ptr[3:0]];
      end
      if (cycles > 2000000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic csr_write(logic [CSR_AW-1:0] addr, int unsigned val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || req.valid || expected_q.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic set_mode(int unsigned echo, int unsigned lim);
      drain();
      csr_write(CSR_AW'(4 * CSR_ECHO_MODE), echo);
      csr_write(CSR_AW'(4 * CSR_LINE_LIMIT), lim);
      m_echo = echo; m_limit = lim;
   endtask

   function automatic void key(int unsigned c);
      key_word_type k;
      k.action = ACT_CHAR; k.ch = c[7:0]; k.idx = 5'($urandom);
      pending_q.push_back(k);
   endfunction

   function automatic void peek(int unsigned i);
      key_word_type k;
      k.action = ACT_READ; k.ch = 8'($urandom); k.idx = i[4:0];
      pending_q.push_back(k);
   endfunction

   function automatic int unsigned text_char();
      case ($urandom_range(0, 3))
         0: return CH_SPACE;
         1: return $urandom_range(32, 126);
         default: return $urandom_range(97, 122);
      endcase
   endfunction

   function automatic void random_item();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) key(text_char());
      else if (r < 52) key(CH_DEL);
      else if (r < 56) key(CH_BS);
      else if (r < 70) begin
         key(CH_ESC); key(CH_LBRK);
         if ($urandom_range(0, 1)) key(CH_ZERO + $urandom_range(0, 9));
         if ($urandom_range(0, 3) == 0) key(CH_SEMI);
         if ($urandom_range(0, 3) == 0) key(CH_ZERO + $urandom_range(0, 9));
         case ($urandom_range(0, 4))
            0: key(CH_UC_C);
            1: key(CH_UC_D);
            2: key(CH_TILDE);
            3: key($urandom_range(0, 255));
            default: key("A");
         endcase
      end else if (r < 76) begin
         key(CH_ESC); key(CH_UC_O); key($urandom_range(0, 1) ? CH_UC_C : CH_UC_D);
      end else if (r < 86) peek($urandom_range(0, 31));
      else if (r < 90) key($urandom_range(0, 1) ? CH_CR : CH_LF);
      else key($urandom_range(0, 255));
   endfunction

   initial begin
      for (int i = 0; i < LINE_MAX_DEF; i++) m_line[i] = '0;
      m_len = 0; m_cur = 0; m_pstate = PS_PLAIN; m_param = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: edits at reset settings
      key("a"); key(" "); key("~"); key("b");
      key(CH_ESC); key(CH_LBRK); key("1"); key(CH_TILDE);
      key(CH_ESC); key(CH_LBRK); key(CH_UC_C);
      key(CH_ESC); key(CH_LBRK); key("3"); key(CH_TILDE);
      key(CH_ESC); key(CH_UC_O); key(CH_UC_C);
      key(CH_BS); key(CH_DEL); peek(0); peek(31); key(CH_CR);
      // parameter saturation and CR inside an escape
      key(CH_ESC); key(CH_LBRK);
      for (int i = 0; i < 7; i++) key("9");
      key(CH_LF); key(CH_SEMI); key(CH_UC_D); key(CH_TAB); key(8'hff); key(8'h00);
      set_mode(ECHO_STAR, 2);
      key("x"); key(CH_CR);
      set_mode(ECHO_MUTE, 63);
      for (int i = 0; i < 34; i++) key("q");
      peek(29); key(CH_CR);
      set_mode(3, 5);
      key("z"); key(CH_BS); key(CH_CR);

      // random phases
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_mode(ECHO_ON, 32);
            1: set_mode(ECHO_STAR, $urandom_range(2, 32));
            2: set_mode(ECHO_ON, 63);
            3: set_mode(ECHO_MUTE, $urandom_range(2, 40));
            4: set_mode(3, 32);
            default: set_mode(ECHO_ON, $urandom_range(8, 32));
         endcase
         for (int i = 0; i < 26; i++) begin
            random_item();
            if (ph == 2 && i == 25) begin
               // hold the sender until every queued word has come back
               while (pending_q.size() > 0 || req.valid) @(posedge clock);
               feed_hold = 1'b1;
               while (expected_q.size() > 0) @(posedge clock);
               feed_hold = 1'b0;
            end
         end
      end

      drain();
      if (errors == 0 && expected_q.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
